### hdl/ipv4f_pkg.sv
`default_nettype none

package ipv4f_pkg;

    // ASCII codes used in the text
    localparam logic [5:0] ASCII_ZERO = 6'd48;
    localparam logic [5:0] ASCII_DOT  = 6'd46;

    // Default depth of the queue between the front and the back
    localparam int IPV4F_QUEUE_DEPTH = 2;

    // Decimal digits of one octet: [2] hundreds, [1] tens, [0] ones
    typedef logic [2:0][3:0] octet_digits_t;

    // One classified request: digits of all four octets (index 3 is the first
    // octet) and, per octet, the index of its leading printed digit
    typedef struct packed {
        logic [3:0][2:0][3:0] digits;
        logic [3:0][1:0]      top_dig;
    } ipv4f_desc_t;

    // Convert one octet to three BCD digits by shift-and-add-3
    function automatic octet_digits_t octet_to_bcd(input logic [7:0] value);
        logic [11:0] bcd;
        integer      i;
        integer      n;
        bcd = 12'd0;
        for (i = 7; i >= 0; i--)
        begin
            for (n = 0; n < 3; n++)
            begin
                if (bcd[n*4 +: 4] >= 4'd5)
                begin
                    bcd[n*4 +: 4] = bcd[n*4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[10:0], value[i]};
        end
        return bcd;
    endfunction

endpackage

`default_nettype wire

### hdl/ipv4f_front.sv
`default_nettype none

module ipv4f_front
    import ipv4f_pkg::*;
(
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] address,
    output logic             push_valid,
    input  wire logic        push_full,
    output ipv4f_desc_t      push_desc
);

    octet_digits_t oct_digits [4];

    // Hold off the sender while the queue is full
    assign in_stall   = push_full;
    assign push_valid = in_valid;

    // Classify each octet: split into digits and find the leading printed digit
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            oct_digits[k]            = octet_to_bcd(address[k*8 +: 8]);
            push_desc.digits[k]      = oct_digits[k];
            if (oct_digits[k][2] != 4'd0)
            begin
                push_desc.top_dig[k] = 2'd2;
            end
            else if (oct_digits[k][1] != 4'd0)
            begin
                push_desc.top_dig[k] = 2'd1;
            end
            else
            begin
                push_desc.top_dig[k] = 2'd0;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/ipv4f_queue.sv
`default_nettype none

module ipv4f_queue
    import ipv4f_pkg::*;
#(
    parameter int DEPTH = IPV4F_QUEUE_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_full,
    input  wire ipv4f_desc_t  push_desc,
    output logic              pop_valid,
    input  wire logic         pop,
    output ipv4f_desc_t       pop_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipv4f_desc_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;

    assign push_full = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign push      = push_valid && !push_full;
    assign pop_desc  = mem[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    // Fill level never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill level above depth");

    // Never drain an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

### hdl/ipv4f_back.sv
`default_nettype none

module ipv4f_back
    import ipv4f_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         pop_valid,
    output logic              pop,
    input  wire ipv4f_desc_t  pop_desc,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [5:0]        text_char,
    output logic              last_char
);

    ipv4f_desc_t cur_reg;
    ipv4f_desc_t cur_next;
    logic        busy_reg;
    logic        busy_next;
    logic [1:0]  oct_reg;
    logic [1:0]  oct_next;
    logic [1:0]  dig_reg;
    logic [1:0]  dig_next;
    logic        dot_pend_reg;
    logic        dot_pend_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [5:0]  text_char_reg;
    logic [5:0]  text_char_next;
    logic        last_char_reg;
    logic        last_char_next;
    logic        advance;
    logic        emit_last;
    logic [3:0]  cur_digit;
    logic [1:0]  oct_inc;
    octet_digits_t cur_octet;

    assign out_valid = out_valid_reg;
    assign text_char = text_char_reg;
    assign last_char = last_char_reg;

    // Output register moves when empty or when the receiver takes it
    assign advance   = !out_valid_reg || !out_stall;
    assign emit_last = busy_reg && !dot_pend_reg && (dig_reg == 2'd0) && (oct_reg == 2'd3);
    assign oct_inc   = oct_reg + 2'd1;
    // Octet 0 of the sequence is the top byte of the address
    assign cur_octet = cur_reg.digits[2'd3 - oct_reg];

    // Pick the digit at the current position
    always_comb
    begin
        case (dig_reg)
            2'd2:    cur_digit = cur_octet[2];
            2'd1:    cur_digit = cur_octet[1];
            default: cur_digit = cur_octet[0];
        endcase
    end

    // Step through dot and digits, load the next request when idle or on the last character
    always_comb
    begin
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        oct_next       = oct_reg;
        dig_next       = dig_reg;
        dot_pend_next  = dot_pend_reg;
        out_valid_next = out_valid_reg;
        text_char_next = text_char_reg;
        last_char_next = last_char_reg;
        pop            = 1'b0;
        if (advance)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                text_char_next = dot_pend_reg ? ASCII_DOT : ASCII_ZERO + {2'b00, cur_digit};
                last_char_next = emit_last;
                if (dot_pend_reg)
                begin
                    dot_pend_next = 1'b0;
                end
                else if (dig_reg != 2'd0)
                begin
                    dig_next = dig_reg - 2'd1;
                end
                else if (oct_reg != 2'd3)
                begin
                    oct_next      = oct_inc;
                    dig_next      = cur_reg.top_dig[2'd3 - oct_inc];
                    dot_pend_next = 1'b1;
                end
            end
            if (!busy_reg || emit_last)
            begin
                pop       = pop_valid;
                busy_next = pop_valid;
                if (pop_valid)
                begin
                    cur_next      = pop_desc;
                    oct_next      = 2'd0;
                    dig_next      = pop_desc.top_dig[3];
                    dot_pend_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            oct_reg       <= 2'd0;
            dig_reg       <= 2'd0;
            dot_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            oct_reg       <= oct_next;
            dig_reg       <= dig_next;
            dot_pend_reg  <= dot_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        text_char_reg <= text_char_next;
        last_char_reg <= last_char_next;
    end

    // A dot is only pending between octets, never before the first
    a_dot_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && dot_pend_reg |-> oct_reg != 2'd0)
        else $error("dot pending before first octet");

    // With no request in progress, a held character closes its address
    a_idle_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && out_valid_reg |-> last_char_reg)
        else $error("idle while a non-final character is held");

    // Text never ends on a dot
    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_char_reg |-> text_char_reg != ASCII_DOT)
        else $error("final character is a dot");

endmodule

`default_nettype wire

### hdl/ipv4_dotted_decimal_formatter_core.sv
// IPv4 dotted-decimal formatter.
// Input channel: in_valid / in_stall carry one 32-bit address per request,
// first octet in bits 31..24. Output channel: out_valid / out_stall carry one
// ASCII character per transfer (text_char) with last_char set on the final
// character of an address. Each address gives 7 to 15 characters, most
// significant octet first, leading zeros dropped, dots between octets.
// The address passes through the queue, the request register and the output
// register before its first character is valid. Throughput: one character per
// cycle while out_stall is low; the single-character output register sets this.
// Requests are classified on entry and wait in a QUEUE_DEPTH-entry queue, so
// new addresses are taken while earlier ones are still being written out;
// in_stall rises only when that queue is full.
// Reset (rst_n low, asynchronous) empties the queue and drops any text in
// progress. A stall on the output holds the current character and freezes the
// sequencer; the input keeps filling the queue until it is full.
`default_nettype none

module ipv4_dotted_decimal_formatter_core
    import ipv4f_pkg::*;
#(
    parameter int QUEUE_DEPTH = IPV4F_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       text_char,
    output logic             last_char
);

    logic        push_valid;
    logic        push_full;
    ipv4f_desc_t push_desc;
    logic        pop_valid;
    logic        pop;
    ipv4f_desc_t pop_desc;

    ipv4f_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .address    (address),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_desc  (push_desc)
    );

    ipv4f_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_desc   (pop_desc)
    );

    ipv4f_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last_char (last_char)
    );

endmodule

`default_nettype wire

### tb/sv/ipv4_dotted_decimal_formatter_core_tb.sv
`default_nettype none

module ipv4_dotted_decimal_formatter_core_tb;
    import ipv4f_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED     = 16;
    localparam int ITEMS_PER_MODE = 40;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 20;

    // Flow-control modes, walked in order during the random part
    typedef enum int { FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH } flow_mode_t;

    // One character of address text
    typedef struct packed {
        logic [5:0] text_char;
        logic       last_char;
    } text_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] address = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  text_char;
    logic        last_char;

    text_beat_t  expected_text[$];
    text_beat_t  want_beat;
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // Directed addresses; an empty string means the text comes from the predictor
    logic [31:0] dir_addr [N_DIRECTED] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h6964_0A01, 32'h0102_0304,
        32'h090A_6364, 32'hC0A8_0001, 32'h7F00_0001, 32'h8000_0000,
        32'h0000_00FF, 32'hC8C9_CAFA, 32'h0A14_1E28, 32'hAAAA_AAAA,
        32'h5555_5555, 32'h1234_5678, 32'hDEAD_BEEF, 32'h6565_0909
    };
    string dir_text [N_DIRECTED] = '{
        "0.0.0.0", "255.255.255.255", "105.100.10.1", "1.2.3.4",
        "9.10.99.100", "192.168.0.1", "127.0.0.1", "128.0.0.0",
        "0.0.0.255", "200.201.202.250", "10.20.30.40", "",
        "", "", "", ""
    };

    int send_pct_of [4] = '{0, 78, 0, 16};
    int recv_pct_of [4] = '{0, 0, 78, 16};

    ipv4_dotted_decimal_formatter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .address   (address),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last_char (last_char)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Append one character, not yet marked as final
    function automatic void push_char(input logic [5:0] ch);
        text_beat_t beat;
        beat.text_char = ch;
        beat.last_char = 1'b0;
        expected_text.push_back(beat);
    endfunction

    // Expected dotted-decimal text of one address, leading zeros dropped
    function automatic void predict_text(input logic [31:0] addr);
        logic [7:0] octet;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
        int         k;
        for (k = 3; k >= 0; k--)
        begin
            octet = addr[k*8 +: 8];
            hund  = 4'(octet / 8'd100);
            tens  = 4'((octet / 8'd10) % 8'd10);
            ones  = 4'(octet % 8'd10);
            if (k != 3)
                push_char(ASCII_DOT);
            if (hund != 4'd0)
                push_char(ASCII_ZERO + {2'b00, hund});
            if (hund != 4'd0 || tens != 4'd0)
                push_char(ASCII_ZERO + {2'b00, tens});
            push_char(ASCII_ZERO + {2'b00, ones});
        end
        expected_text[expected_text.size() - 1].last_char = 1'b1;
    endfunction

    // Pick an octet biased toward digit-count boundaries and inner zeros
    function automatic logic [7:0] pick_octet();
        logic [7:0] edges [6] = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd255};
        case ($urandom_range(3))
            0: return 8'($urandom_range(255));
            1: return 8'($urandom_range(9));
            2: return edges[$urandom_range(5)];
            default: return 8'($urandom_range(100, 109) + 100 * $urandom_range(0, 1));
        endcase
    endfunction

    // Offer one address, hold it until taken, then record its text
    task automatic send_request(input logic [31:0] addr, input string text);
        text_beat_t beat;
        int         i;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        address  <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (text.len() == 0)
        begin
            predict_text(addr);
        end
        else
        begin
            for (i = 0; i < text.len(); i++)
            begin
                beat.text_char = 6'(text[i]);
                beat.last_char = (i == text.len() - 1);
                expected_text.push_back(beat);
            end
        end
    endtask

    // Randomize the receiver stall every cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Check each accepted character against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual char=%0d last=%0b",
                         $time, text_char, last_char);
                error_count++;
            end
            else
            begin
                want_beat = expected_text.pop_front();
                if (text_char !== want_beat.text_char)
                begin
                    $display("%0t: text_char mismatch: expected %0d, actual %0d",
                             $time, want_beat.text_char, text_char);
                    error_count++;
                end
                if (last_char !== want_beat.last_char)
                begin
                    $display("%0t: last_char mismatch: expected %0b, actual %0b",
                             $time, want_beat.last_char, last_char);
                    error_count++;
                end
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[ipv4_dotted_decimal_formatter_core] ERROR");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain
    initial
    begin
        int         i;
        flow_mode_t mode;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            send_request(dir_addr[i], dir_text[i]);

        for (mode = FLOW_FREE; ; mode = mode.next())
        begin
            send_idle_pct  = send_pct_of[mode];
            recv_stall_pct = recv_pct_of[mode];
            for (i = 0; i < ITEMS_PER_MODE; i++)
            begin
                if ($urandom_range(3) == 0)
                    send_request($urandom, "");
                else
                    send_request({pick_octet(), pick_octet(), pick_octet(), pick_octet()}, "");
            end
            if (mode == FLOW_BOTH)
                break;
        end

        in_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[ipv4_dotted_decimal_formatter_core] OK");
        else
            $display("[ipv4_dotted_decimal_formatter_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
